// ===== rtl/tama_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tama_pkg;

   // width of one sensor word and of one conditioned mean
   localparam int DATA_W = 16;
   localparam int AXES   = 3;

   typedef logic signed [DATA_W-1:0] sample_type;

   // one three-axis entry, element 0 is x, 1 is y, 2 is z
   typedef logic [AXES-1:0][DATA_W-1:0] axis3_type;

   typedef enum logic [1:0] {
      OP_ACC = 2'd0,
      OP_MAG = 2'd1,
      OP_CAL = 2'd2
   } opcode_type;

endpackage

`default_nettype wire

// ===== rtl/tama_req_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tama_req_if;
   import tama_pkg::*;

   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   sample_type raw_x;
   sample_type raw_y;
   sample_type raw_z;

   modport source (output valid, output opcode, output raw_x, output raw_y, output raw_z,
                   input ready);
   modport sink   (input valid, input opcode, input raw_x, input raw_y, input raw_z,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/tama_rsp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface tama_rsp_if;
   import tama_pkg::*;

   logic       valid;
   logic       ready;
   logic       sensor_kind;
   sample_type avg_x;
   sample_type avg_y;
   sample_type avg_z;
   sample_type min_x;
   sample_type min_y;
   sample_type min_z;
   sample_type max_x;
   sample_type max_y;
   sample_type max_z;

   modport source (output valid, output sensor_kind,
                   output avg_x, output avg_y, output avg_z,
                   output min_x, output min_y, output min_z,
                   output max_x, output max_y, output max_z,
                   input ready);
   modport sink   (input valid, input sensor_kind,
                   input avg_x, input avg_y, input avg_z,
                   input min_x, input min_y, input min_z,
                   input max_x, input max_y, input max_z,
                   output ready);
endinterface

`default_nettype wire

// ===== rtl/three_axis_moving_average_calib.sv =====
`timescale 1ns / 1ps
`default_nettype none

// three-axis moving average with magnetometer min/max calibration
//
// req carries one beat per sample: opcode 0 accelerometer, 1 magnetometer,
// 2 start calibration, 3 is taken and dropped. rsp returns one beat for
// every accelerometer or magnetometer beat, in order, with the window means
// and the current min/max registers. csr is an apb-style port for the six
// offsets at byte addresses 0,4,..,20; pready is tied high.
//
// throughput: one beat per cycle while rsp is ready. each sensor keeps a running sum next to
// its chain of WINDOW cells, so a sample is one add and subtract per axis.
// a result beat passes the sum register, the reciprocal multiply register and the output
// register after its request beat is taken.
//
// reset (synchronous) clears the window cells, sums, min/max, calibrating
// flag and all valid bits; the offsets go to their default values.
// when rsp stalls, the output register holds and the stages behind it keep
// filling any bubbles; req.ready drops once every stage is occupied.
module three_axis_moving_average_calib #(
   parameter int WINDOW = 10
) (
   input  logic        clock,
   input  logic        reset,
   tama_req_if.sink    req,
   tama_rsp_if.source  rsp,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   import tama_pkg::*;

   localparam int SUM_W = DATA_W + $clog2(WINDOW);

   typedef enum logic [2:0] {
      REG_ACC_OFF_X = 3'd0,
      REG_ACC_OFF_Y = 3'd1,
      REG_ACC_OFF_Z = 3'd2,
      REG_MAG_OFF_X = 3'd3,
      REG_MAG_OFF_Y = 3'd4,
      REG_MAG_OFF_Z = 3'd5
   } reg_index_type;

   typedef logic signed [SUM_W-1:0] sum_type;

   // ---------------- configuration registers ----------------
   sample_type acc_off_ff [AXES];
   sample_type mag_off_ff [AXES];
   logic [2:0] csr_index;
   logic       csr_write;
   sample_type csr_rd_val;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[4:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_off_ff[0] <= -16'sd135;
         acc_off_ff[1] <= -16'sd250;
         acc_off_ff[2] <= 16'sd500;
         mag_off_ff[0] <= '0;
         mag_off_ff[1] <= '0;
         mag_off_ff[2] <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_ACC_OFF_X: acc_off_ff[0] <= csr_pwdata[DATA_W-1:0];
            REG_ACC_OFF_Y: acc_off_ff[1] <= csr_pwdata[DATA_W-1:0];
            REG_ACC_OFF_Z: acc_off_ff[2] <= csr_pwdata[DATA_W-1:0];
            REG_MAG_OFF_X: mag_off_ff[0] <= csr_pwdata[DATA_W-1:0];
            REG_MAG_OFF_Y: mag_off_ff[1] <= csr_pwdata[DATA_W-1:0];
            REG_MAG_OFF_Z: mag_off_ff[2] <= csr_pwdata[DATA_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_ACC_OFF_X: csr_rd_val = acc_off_ff[0];
         REG_ACC_OFF_Y: csr_rd_val = acc_off_ff[1];
         REG_ACC_OFF_Z: csr_rd_val = acc_off_ff[2];
         REG_MAG_OFF_X: csr_rd_val = mag_off_ff[0];
         REG_MAG_OFF_Y: csr_rd_val = mag_off_ff[1];
         REG_MAG_OFF_Z: csr_rd_val = mag_off_ff[2];
         default:       csr_rd_val = '0;
      endcase
   end

   // read data sign-extended to the bus
   assign csr_prdata = {{(32-DATA_W){csr_rd_val[DATA_W-1]}}, csr_rd_val};

   // ---------------- pipeline handshake ----------------
   logic       s1_valid_ff;
   opcode_type s1_op_ff;
   sum_type    s1_sum_ff [AXES];
   logic       s2_valid_ff;
   opcode_type s2_op_ff;
   logic       rsp_valid_ff;
   logic       s1_ready;
   logic       s2_ready;
   logic       s3_ready;
   logic       req_beat;
   logic       req_enter;
   logic       acc_beat;
   logic       mag_beat;
   logic       s3_move;

   assign s3_ready  = !rsp_valid_ff || rsp.ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req.ready = s1_ready;

   assign req_beat  = req.valid && req.ready;
   assign acc_beat  = req_beat && (req.opcode == OP_ACC);
   assign mag_beat  = req_beat && (req.opcode == OP_MAG);
   // opcode three is taken but never enters the pipe
   assign req_enter = acc_beat || mag_beat || (req_beat && (req.opcode == OP_CAL));
   assign s3_move   = s3_ready && s2_valid_ff;

   // ---------------- window chains and running sums ----------------
   axis3_type acc_store;
   axis3_type mag_store;
   axis3_type acc_chain [WINDOW];
   axis3_type mag_chain [WINDOW];
   sum_type   acc_sum_ff [AXES];
   sum_type   mag_sum_ff [AXES];
   sum_type   acc_sum_in [AXES];
   sum_type   mag_sum_in [AXES];

   // x and y are mounted inverted; accelerometer offset removed before storing
   assign acc_store[0] = DATA_W'(16'sd0 - req.raw_x - acc_off_ff[0]);
   assign acc_store[1] = DATA_W'(16'sd0 - req.raw_y - acc_off_ff[1]);
   assign acc_store[2] = DATA_W'(req.raw_z - acc_off_ff[2]);
   assign mag_store[0] = DATA_W'(16'sd0 - req.raw_x);
   assign mag_store[1] = DATA_W'(16'sd0 - req.raw_y);
   assign mag_store[2] = req.raw_z;

   for (genvar i = 0; i < WINDOW; i++) begin : g_cells
      if (i == 0) begin : g_head
         tama_cell u_acc_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (acc_beat),
            .entry_in  (acc_store),
            .entry_out (acc_chain[i])
         );
         tama_cell u_mag_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (mag_beat),
            .entry_in  (mag_store),
            .entry_out (mag_chain[i])
         );
      end else begin : g_body
         tama_cell u_acc_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (acc_beat),
            .entry_in  (acc_chain[i-1]),
            .entry_out (acc_chain[i])
         );
         tama_cell u_mag_cell (
            .clock     (clock),
            .reset     (reset),
            .shift_en  (mag_beat),
            .entry_in  (mag_chain[i-1]),
            .entry_out (mag_chain[i])
         );
      end
   end

   // new sample in, the entry falling off the end of the chain out
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         acc_sum_in[a] = acc_sum_ff[a] + SUM_W'(sample_type'(acc_store[a]))
                         - SUM_W'(sample_type'(acc_chain[WINDOW-1][a]));
         mag_sum_in[a] = mag_sum_ff[a] + SUM_W'(sample_type'(mag_store[a]))
                         - SUM_W'(sample_type'(mag_chain[WINDOW-1][a]));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            acc_sum_ff[a] <= '0;
            mag_sum_ff[a] <= '0;
         end
      end else begin
         if (acc_beat) begin
            acc_sum_ff <= acc_sum_in;
         end
         if (mag_beat) begin
            mag_sum_ff <= mag_sum_in;
         end
      end
   end

   // ---------------- stage 1: sum snapshot ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= req_enter;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready && req_enter) begin
         s1_op_ff <= opcode_type'(req.opcode);
         for (int a = 0; a < AXES; a++) begin
            s1_sum_ff[a] <= (req.opcode == OP_MAG) ? mag_sum_in[a] : acc_sum_in[a];
         end
      end
   end

   // ---------------- stage 2: divide by the window length ----------------
   sample_type mean_q [AXES];

   for (genvar a = 0; a < AXES; a++) begin : g_mean
      tama_mean #(
         .WINDOW (WINDOW)
      ) u_mean (
         .clock    (clock),
         .load     (s2_ready),
         .sum_in   (s1_sum_ff[a]),
         .mean_out (mean_q[a])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_op_ff <= s1_op_ff;
      end
   end

   // ---------------- stage 3: offset, calibration, output ----------------
   sample_type avg_in [AXES];
   sample_type rsp_avg_ff [AXES];
   sample_type mag_min_ff [AXES];
   sample_type mag_max_ff [AXES];
   sample_type mag_min_in [AXES];
   sample_type mag_max_in [AXES];
   logic       calibrating_ff;
   logic       rsp_kind_ff;

   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         avg_in[a]     = (s2_op_ff == OP_MAG) ? DATA_W'(mean_q[a] - mag_off_ff[a]) : mean_q[a];
         mag_min_in[a] = mag_min_ff[a];
         mag_max_in[a] = mag_max_ff[a];
         if (s2_op_ff == OP_CAL) begin
            mag_min_in[a] = '0;
            mag_max_in[a] = '0;
         end else if (s2_op_ff == OP_MAG && calibrating_ff) begin
            if (mag_min_ff[a] > avg_in[a]) begin
               mag_min_in[a] = avg_in[a];
            end
            if (mag_max_ff[a] < avg_in[a]) begin
               mag_max_in[a] = avg_in[a];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff   <= 1'b0;
         calibrating_ff <= 1'b0;
         for (int a = 0; a < AXES; a++) begin
            mag_min_ff[a] <= '0;
            mag_max_ff[a] <= '0;
         end
      end else begin
         if (s3_ready) begin
            rsp_valid_ff <= s2_valid_ff && (s2_op_ff != OP_CAL);
         end
         if (s3_move) begin
            mag_min_ff <= mag_min_in;
            mag_max_ff <= mag_max_in;
            // calibration never stops once started
            if (s2_op_ff == OP_CAL) begin
               calibrating_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s3_move) begin
         rsp_kind_ff <= (s2_op_ff == OP_MAG);
         rsp_avg_ff  <= avg_in;
      end
   end

   // min/max only change when a beat moves out, so the live registers
   // already match the beat that sits in the output register
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.sensor_kind = rsp_kind_ff;
   assign rsp.avg_x       = rsp_avg_ff[0];
   assign rsp.avg_y       = rsp_avg_ff[1];
   assign rsp.avg_z       = rsp_avg_ff[2];
   assign rsp.min_x       = mag_min_ff[0];
   assign rsp.min_y       = mag_min_ff[1];
   assign rsp.min_z       = mag_min_ff[2];
   assign rsp.max_x       = mag_max_ff[0];
   assign rsp.max_y       = mag_max_ff[1];
   assign rsp.max_z       = mag_max_ff[2];

   // ---------------- assertions ----------------
   a_reset_no_beat: assert property (@(posedge clock) reset |=> !rsp_valid_ff)
      else $error("result beat right after reset");

   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_ready |=> s1_valid_ff && $stable(s1_op_ff))
      else $error("stage 1 lost its beat during a stall");

   for (genvar a = 0; a < AXES; a++) begin : g_chk
      a_idle_zero: assert property (@(posedge clock) disable iff (reset)
         !calibrating_ff |-> mag_min_ff[a] == '0 && mag_max_ff[a] == '0)
         else $error("min/max moved before calibration started");

      a_cal_clear: assert property (@(posedge clock) disable iff (reset)
         s3_move && s2_op_ff == OP_CAL |=>
            calibrating_ff && mag_min_ff[a] == '0 && mag_max_ff[a] == '0)
         else $error("start of calibration did not clear min/max");
   end

endmodule

`default_nettype wire

// ===== rtl/tama_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

// one window slot: takes its neighbor's entry on every shift
module tama_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                shift_en,
   input  tama_pkg::axis3_type entry_in,
   output tama_pkg::axis3_type entry_out
);
   import tama_pkg::*;

   axis3_type entry_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else if (shift_en) begin
         entry_ff <= entry_in;
      end
   end

   assign entry_out = entry_ff;

endmodule

`default_nettype wire

// ===== rtl/tama_mean.sv =====
`timescale 1ns / 1ps
`default_nettype none

// window sum divided by WINDOW, truncated toward zero
// reciprocal multiply on the magnitude, exact for every reachable sum
module tama_mean #(
   parameter int WINDOW = 10
) (
   input  logic                                     clock,
   input  logic                                     load,
   input  logic signed [16+$clog2(WINDOW)-1:0]      sum_in,
   output tama_pkg::sample_type                     mean_out
);
   import tama_pkg::*;

   localparam int SUM_W  = DATA_W + $clog2(WINDOW);
   localparam int SHIFT  = SUM_W + $clog2(WINDOW);
   localparam int PROD_W = SUM_W + SHIFT + 1;
   localparam logic [SHIFT:0] RECIP =
      (SHIFT+1)'(((64'd1 << SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

   logic [SUM_W-1:0]  mag;
   logic [PROD_W-1:0] prod_ff;
   logic              neg_ff;
   logic [DATA_W:0]   quot;

   assign mag = sum_in[SUM_W-1] ? SUM_W'(-sum_in) : SUM_W'(sum_in);

   always_ff @(posedge clock) begin
      if (load) begin
         neg_ff  <= sum_in[SUM_W-1];
         prod_ff <= PROD_W'(mag) * PROD_W'(RECIP);
      end
   end

   assign quot     = prod_ff[SHIFT +: DATA_W+1];
   assign mean_out = neg_ff ? DATA_W'(~quot + 1'b1) : DATA_W'(quot);

endmodule

`default_nettype wire

// ===== tb/three_axis_moving_average_calib_test.sv =====
`timescale 1ns / 1ps

module three_axis_moving_average_calib_test;
   import tama_pkg::*;

   localparam int WINDOW        = 10;
   localparam int CYCLE_LIMIT   = 200000;
   localparam int SETTLE_CYCLES = 8;       // pipeline drain plus margin
   localparam int CHUNK_BEATS   = 205;     // six random chunks, about 1230 beats

   // opcode 3 is taken by the block and dropped
   localparam logic [1:0] OP_IGNORED = 2'd3;

   // offset registers, byte address is 4 * index
   typedef enum int {
      REG_ACC_OFF_X = 0,
      REG_ACC_OFF_Y = 1,
      REG_ACC_OFF_Z = 2,
      REG_MAG_OFF_X = 3,
      REG_MAG_OFF_Y = 4,
      REG_MAG_OFF_Z = 5
   } offset_reg_type;

   typedef struct packed {
      logic [1:0]  opcode;
      logic [15:0] x;
      logic [15:0] y;
      logic [15:0] z;
   } sensor_beat_type;

   // element 0 is x, 1 is y, 2 is z
   typedef struct packed {
      logic             sensor_kind;
      logic [2:0][15:0] avg;
      logic [2:0][15:0] lo;
      logic [2:0][15:0] hi;
   } conditioned_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [4:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   wire  [31:0] csr_prdata;
   wire         csr_pready;

   tama_req_if req_bus ();
   tama_rsp_if rsp_bus ();

   three_axis_moving_average_calib #(.WINDOW(WINDOW)) u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   // beats waiting for the driver, and conditioned results still owed by the block
   sensor_beat_type pending_beats[$];
   conditioned_type expected_results[$];

   int  send_idle_pct = 0;
   int  recv_idle_pct = 0;
   logic req_taken    = 1'b0;
   int  error_count   = 0;
   int  cycle_count   = 0;

   // ---------------------------------------------------------------
   // predictor state: window rings, ring positions, calibration
   // registers and the six offsets
   // ---------------------------------------------------------------
   logic [15:0]      acc_ring [3][WINDOW];
   logic [15:0]      mag_ring [3][WINDOW];
   int               acc_pos;
   int               mag_pos;
   logic             calib_on;
   logic [2:0][15:0] cal_min;
   logic [2:0][15:0] cal_max;
   logic [2:0][15:0] acc_off;
   logic [2:0][15:0] mag_off;

   // window mean of one axis, signed sum divided with truncation toward zero
   function automatic logic [15:0] window_mean(input bit from_mag, input int axis);
      int sum;
      sum = 0;
      for (int i = 0; i < WINDOW; i++) begin
         if (from_mag) sum += $signed(mag_ring[axis][i]);
         else sum += $signed(acc_ring[axis][i]);
      end
      return 16'(sum / WINDOW);
   endfunction

   // applies one accepted beat to the predictor, returns 1 when a result is due
   function automatic bit condition_beat(input sensor_beat_type b, output conditioned_type r);
      logic [2:0][15:0] s;
      // x and y are mounted inverted; negating the most negative word wraps to itself
      s[0] = 16'd0 - b.x;
      s[1] = 16'd0 - b.y;
      s[2] = b.z;
      r = '0;
      case (b.opcode)
         OP_CAL: begin
            calib_on = 1'b1;
            cal_min  = '0;
            cal_max  = '0;
            return 1'b0;
         end
         OP_ACC: begin
            // offset removed before the sample enters the ring
            for (int a = 0; a < 3; a++) begin
               acc_ring[a][acc_pos] = s[a] - acc_off[a];
               r.avg[a] = window_mean(1'b0, a);
            end
            acc_pos = (acc_pos == WINDOW - 1) ? 0 : acc_pos + 1;
         end
         OP_MAG: begin
            // offset removed from the mean, min/max widen only while calibrating
            for (int a = 0; a < 3; a++) begin
               mag_ring[a][mag_pos] = s[a];
               r.avg[a] = window_mean(1'b1, a) - mag_off[a];
               if (calib_on) begin
                  if ($signed(cal_min[a]) > $signed(r.avg[a])) cal_min[a] = r.avg[a];
                  if ($signed(cal_max[a]) < $signed(r.avg[a])) cal_max[a] = r.avg[a];
               end
            end
            mag_pos = (mag_pos == WINDOW - 1) ? 0 : mag_pos + 1;
         end
         default: begin
            return 1'b0;
         end
      endcase
      r.sensor_kind = (b.opcode == OP_MAG);
      r.lo = cal_min;
      r.hi = cal_max;
      return 1'b1;
   endfunction

   function automatic void report_error(input string why, input conditioned_type want,
                                        input conditioned_type got);
      error_count++;
      if (error_count <= 10) begin
         $display("%0t: %s", $realtime, why);
         $display("   exp kind %0d avg %h min %h max %h", want.sensor_kind, want.avg,
                  want.lo, want.hi);
         $display("   got kind %0d avg %h min %h max %h", got.sensor_kind, got.avg,
                  got.lo, got.hi);
      end
   endfunction

   // ---------------------------------------------------------------
   // driver: presents queued beats at the falling edge, holds a beat
   // until it is taken, idles at random between beats
   // ---------------------------------------------------------------
   always @(negedge clock) begin : sample_driver
      sensor_beat_type next_beat;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_taken) begin
         if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            next_beat = pending_beats.pop_front();
            req_bus.opcode <= next_beat.opcode;
            req_bus.raw_x  <= next_beat.x;
            req_bus.raw_y  <= next_beat.y;
            req_bus.raw_z  <= next_beat.z;
            req_bus.valid  <= 1'b1;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // result side back-pressure
   always @(negedge clock) begin
      rsp_bus.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
   end

   // ---------------------------------------------------------------
   // monitor: checks a result beat against the oldest expectation, then
   // runs the predictor on a request beat taken at the same edge
   // ---------------------------------------------------------------
   always @(posedge clock) begin : result_monitor
      conditioned_type got;
      conditioned_type want;
      sensor_beat_type taken;
      bit              bad;
      if (reset) begin
         req_taken <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.sensor_kind = rsp_bus.sensor_kind;
            got.avg = {rsp_bus.avg_z, rsp_bus.avg_y, rsp_bus.avg_x};
            got.lo  = {rsp_bus.min_z, rsp_bus.min_y, rsp_bus.min_x};
            got.hi  = {rsp_bus.max_z, rsp_bus.max_y, rsp_bus.max_x};
            if (expected_results.size() == 0) begin
               report_error("result beat with nothing expected", '0, got);
            end else begin
               want = expected_results.pop_front();
               bad = (got.sensor_kind !== want.sensor_kind);
               for (int a = 0; a < 3; a++) begin
                  bad |= (got.avg[a] !== want.avg[a]);
                  bad |= (got.lo[a] !== want.lo[a]);
                  bad |= (got.hi[a] !== want.hi[a]);
               end
               if (bad) report_error("result beat mismatch", want, got);
            end
         end
         req_taken <= req_bus.valid && req_bus.ready;
         if (req_bus.valid && req_bus.ready) begin
            taken = {req_bus.opcode, req_bus.raw_x, req_bus.raw_y, req_bus.raw_z};
            if (condition_beat(taken, want)) expected_results.push_back(want);
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("three_axis_moving_average_calib_test NOT OK");
         $finish;
      end
   end

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_beat(input logic [1:0] op, input logic [15:0] x, input logic [15:0] y,
                             input logic [15:0] z);
      pending_beats.push_back({op, x, y, z});
   endtask

   // mostly full-range words, with the extremes and values near zero mixed in
   function automatic logic [15:0] random_word();
      case ($urandom_range(9))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'($urandom_range(200)) - 16'd100;
         default: return 16'($urandom);
      endcase
   endfunction

   task automatic queue_random(input int count);
      int          pick;
      logic [1:0]  op;
      for (int n = 0; n < count; n++) begin
         pick = $urandom_range(99);
         if (pick < 45) op = OP_ACC;
         else if (pick < 94) op = OP_MAG;
         else if (pick < 97) op = OP_CAL;
         else op = OP_IGNORED;
         queue_beat(op, random_word(), random_word(), random_word());
      end
   endtask

   // wait until every beat is taken and every result is back, then let
   // the pipeline empty out behind beats that produce nothing
   task automatic settle();
      while (pending_beats.size() != 0 || req_bus.valid || expected_results.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, then access until pready
   task automatic write_offset(input offset_reg_type idx, input logic [15:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= 5'(4 * int'(idx));
      csr_pwdata  <= {{16{value[15]}}, value};
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (int'(idx) <= int'(REG_ACC_OFF_Z)) acc_off[int'(idx)] = value;
      else mag_off[int'(idx) - int'(REG_MAG_OFF_X)] = value;
   endtask

   task automatic load_offsets(input logic [15:0] ax, input logic [15:0] ay,
                               input logic [15:0] az, input logic [15:0] mx,
                               input logic [15:0] my, input logic [15:0] mz);
      write_offset(REG_ACC_OFF_X, ax);
      write_offset(REG_ACC_OFF_Y, ay);
      write_offset(REG_ACC_OFF_Z, az);
      write_offset(REG_MAG_OFF_X, mx);
      write_offset(REG_MAG_OFF_Y, my);
      write_offset(REG_MAG_OFF_Z, mz);
   endtask

   // ---------------------------------------------------------------
   // test sequence
   // ---------------------------------------------------------------
   initial begin
      req_bus.valid  = 1'b0;
      req_bus.opcode = OP_ACC;
      req_bus.raw_x  = '0;
      req_bus.raw_y  = '0;
      req_bus.raw_z  = '0;
      rsp_bus.ready  = 1'b0;
      csr_psel       = 1'b0;
      csr_penable    = 1'b0;
      csr_pwrite     = 1'b0;
      csr_paddr      = '0;
      csr_pwdata     = '0;

      // predictor starts from the reset state
      for (int a = 0; a < 3; a++) begin
         for (int i = 0; i < WINDOW; i++) begin
            acc_ring[a][i] = '0;
            mag_ring[a][i] = '0;
         end
      end
      acc_pos  = 0;
      mag_pos  = 0;
      calib_on = 1'b0;
      cal_min  = '0;
      cal_max  = '0;
      acc_off  = {16'd500, -16'sd250, -16'sd135};
      mag_off  = '0;

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed part, offsets left at their reset values
      send_idle_pct = 11;
      recv_idle_pct = 80;
      // accelerometer extremes, most negative word negates to itself
      queue_beat(OP_ACC, 16'h0000, 16'h0000, 16'h0000);
      queue_beat(OP_ACC, 16'h8000, 16'h8000, 16'h8000);
      queue_beat(OP_ACC, 16'h7fff, 16'h7fff, 16'h7fff);
      queue_beat(OP_ACC, 16'hffff, 16'h0001, 16'hffff);
      // magnetometer before calibration, min/max must stay zero
      queue_beat(OP_MAG, 16'h8000, 16'h7fff, 16'h8000);
      queue_beat(OP_MAG, 16'h7fff, 16'h8000, 16'h7fff);
      // ignored opcode, no result and no state change
      queue_beat(OP_IGNORED, 16'h1234, 16'h8000, 16'h7fff);
      queue_beat(OP_CAL, 16'h5555, 16'haaaa, 16'h0f0f);
      // enough magnetometer beats to wrap the ring, swinging both ways
      for (int n = 0; n < 9; n++) begin
         if (n % 2 == 0) queue_beat(OP_MAG, 16'h7fff, 16'h8000, 16'h8000);
         else queue_beat(OP_MAG, 16'h8000, 16'h7fff, 16'h7fff);
      end
      // finish one full accelerometer ring
      for (int n = 0; n < 6; n++) queue_beat(OP_ACC, 16'h8000, 16'h7fff, 16'h8000);
      // restart calibration clears min/max again
      queue_beat(OP_CAL, 16'hffff, 16'hffff, 16'hffff);
      queue_beat(OP_MAG, 16'h0001, 16'hfffe, 16'h8000);
      settle();

      // random part in six chunks, each with its own offset setting:
      // sender idles lightly first, then the receiver, then neither
      for (int chunk = 0; chunk < 6; chunk++) begin
         case (chunk)
            0: load_offsets(16'h7fff, 16'h8000, 16'h0000, 16'h8000, 16'h7fff, 16'hffff);
            2: load_offsets(16'h8000, 16'h7fff, 16'hffff, 16'h7fff, 16'h8000, 16'h0000);
            5: load_offsets('0, '0, '0, '0, '0, '0);
            default: load_offsets(16'($urandom), 16'($urandom), 16'($urandom),
                                  16'($urandom), 16'($urandom), 16'($urandom));
         endcase
         case (chunk / 2)
            0: begin
               send_idle_pct = 11;
               recv_idle_pct = 80;
            end
            1: begin
               send_idle_pct = 80;
               recv_idle_pct = 11;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         queue_random(CHUNK_BEATS);
         settle();
      end

      if (error_count == 0 && expected_results.size() == 0) begin
         $display("three_axis_moving_average_calib_test OK");
      end else begin
         $display("three_axis_moving_average_calib_test NOT OK");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tama_pkg.sv
rtl/tama_req_if.sv
rtl/tama_rsp_if.sv
rtl/tama_cell.sv
rtl/tama_mean.sv
rtl/three_axis_moving_average_calib.sv
tb/three_axis_moving_average_calib_test.sv
